[hw/rtl/qphm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qphm_pkg
// Shared types and constants for the quadratic probe hash map.
// ----------------------------------------------------------------------------
package qphm_pkg;

    localparam int unsigned DEF_CAPACITY = 1024;

    localparam logic [31:0] HASH_MULT  = 32'h045d_9f3b;
    localparam int unsigned HASH_SHIFT = 16;

    // request action codes
    localparam logic [1:0] ACT_GET  = 2'd0;
    localparam logic [1:0] ACT_PUT  = 2'd1;
    localparam logic [1:0] ACT_DROP = 2'd2;

    // slot marks
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] lookup_key;
        logic [63:0] new_value;
        logic [63:0] default_value;
    } t_req;

    typedef struct packed {
        logic [63:0] result_value;
        logic        found;
        logic        status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HOME,
        ST_PROBE
    } t_state;

endpackage

[hw/rtl/quadratic_probe_hash_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_map
// Key/value table, open addressing with quadratic probing, over slot memories sharing one read address.
// ----------------------------------------------------------------------------
// Usage:
//   A request (get, put or drop) is taken on i_req when start is high and
//   busy is low. Exactly one response per request appears on o_rsp for a
//   single cycle, flagged by o_done; the receiver cannot stall it and must
//   take it in that cycle.
// Timing:
//   The key is hashed in states HASH1 and HASH2 (one 32-bit multiply in
//   each), HOME fetches the home slot, then PROBE walks the probes through
//   the slot memory. The response is strobed as the block returns to idle,
//   and busy drops in that same cycle, so a new request may be issued
//   alongside the response; none is taken while one is in flight. The
//   walk length, bounded by CAPACITY, sets how long each request takes.
// Reset:
//   After reset the slot marks are swept to empty, one slot per cycle, over
//   all CAPACITY slots; busy stays high for the whole sweep. Keys and values
//   are not cleared: they are only ever read from occupied slots.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_map #(
    parameter int unsigned CAPACITY = qphm_pkg::DEF_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  qphm_pkg::t_req  i_req,
    output logic            o_done,
    output qphm_pkg::t_rsp  o_rsp
);
    import qphm_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // slot index mask; also the last probe number and the last swept slot
    localparam logic [IW-1:0] IDX_MASK = IW'(CAPACITY - 1);

    // slot memories: marks, keys, values share one read address
    logic [1:0]  mem_mark [CAPACITY];
    logic [63:0] mem_key  [CAPACITY];
    logic [63:0] mem_val  [CAPACITY];

    t_state      r_state, n_state;
    t_req        r_req;
    logic [31:0] r_x, n_x;
    logic [IW-1:0] r_idx, n_idx;       // hash + p*p of the probe in hand, unmasked
    logic [IW-1:0] r_step, n_step;     // 2p+1, so idx(p+1) = idx(p) + step
    logic [IW-1:0] r_cnt, n_cnt;       // probe number p
    logic [IW-1:0] r_clr;              // mark sweep pointer
    logic          r_free_ok, n_free_ok;
    logic [IW-1:0] r_free_at, n_free_at;
    logic          r_done, n_done;
    t_rsp          r_rsp, n_rsp;

    // registered read data
    logic [1:0]  r_mark_q;
    logic [63:0] r_key_q;
    logic [63:0] r_val_q;

    // probe decision
    logic [31:0] w_x_in;
    logic [31:0] w_hash;
    logic        w_empty, w_used, w_match, w_tomb, w_stop;
    logic        w_is_get, w_is_put, w_is_drop;
    logic [IW-1:0] w_slot, w_rd_addr;

    // write ports
    logic          w_mark_we, w_key_we, w_val_we;
    logic [IW-1:0] w_mark_addr, w_kv_addr;
    logic [1:0]    w_mark_data;

    // ---------------- hashing and probe decision ----------------
    assign w_x_in = (r_state == ST_HASH1) ? r_req.lookup_key[31:0] : r_x;
    assign w_hash = (r_x >> HASH_SHIFT) ^ r_x;

    // slot in hand and next read slot, both masked to the table
    assign w_slot    = r_idx & IDX_MASK;
    assign w_rd_addr = n_idx & IDX_MASK;

    assign w_is_get  = (r_req.action == ACT_GET);
    assign w_is_put  = (r_req.action == ACT_PUT);
    assign w_is_drop = (r_req.action == ACT_DROP);

    assign w_empty = (r_mark_q == MARK_EMPTY);
    assign w_used  = (r_mark_q == MARK_USED);
    assign w_tomb  = !w_empty && !w_used;
    assign w_match = w_used && (r_key_q == r_req.lookup_key);
    assign w_stop  = w_empty || w_match || (r_cnt == IDX_MASK);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == IDX_MASK) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_HASH1;
            end
            ST_HASH1: n_state = ST_HASH2;
            ST_HASH2: n_state = ST_HOME;
            ST_HOME:  n_state = ST_PROBE;
            ST_PROBE: begin
                if (w_stop) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        busy        = (r_state != ST_IDLE);
        n_x         = r_x;
        n_idx       = r_idx;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_free_ok   = r_free_ok;
        n_free_at   = r_free_at;
        n_done      = 1'b0;
        n_rsp       = r_rsp;
        w_mark_we   = 1'b0;
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_mark_addr = w_slot;
        w_kv_addr   = w_slot;
        w_mark_data = MARK_EMPTY;

        case (r_state)
            ST_CLEAR: begin
                w_mark_we   = 1'b1;
                w_mark_addr = r_clr;
                w_mark_data = MARK_EMPTY;
            end
            ST_HASH1, ST_HASH2: begin
                n_x = 32'((w_x_in >> HASH_SHIFT) ^ w_x_in) * HASH_MULT;
            end
            ST_HOME: begin
                n_idx     = w_hash[IW-1:0];
                n_step    = IW'(1);
                n_cnt     = '0;
                n_free_ok = 1'b0;
                n_free_at = '0;
            end
            ST_PROBE: begin
                n_idx  = r_idx + r_step;
                n_step = r_step + IW'(2);
                n_cnt  = r_cnt + IW'(1);
                // first tombstone or empty slot on the path
                if ((w_empty || w_tomb) && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free_at = w_slot;
                end
                if (w_stop) begin
                    n_done                = 1'b1;
                    n_rsp.result_value    = r_req.default_value;
                    n_rsp.found           = 1'b0;
                    n_rsp.status          = 1'b0;
                    if (w_match && (w_is_get || w_is_put || w_is_drop)) begin
                        n_rsp.result_value = r_val_q;
                        n_rsp.found        = 1'b1;
                        if (w_is_put) begin
                            w_val_we = 1'b1;
                        end else if (w_is_drop) begin
                            w_mark_we   = 1'b1;
                            w_mark_data = MARK_DELETED;
                        end
                    end else if (!w_match && w_is_put) begin
                        if (n_free_ok) begin
                            w_mark_we   = 1'b1;
                            w_key_we    = 1'b1;
                            w_val_we    = 1'b1;
                            w_mark_addr = n_free_at;
                            w_kv_addr   = n_free_at;
                            w_mark_data = MARK_USED;
                        end else begin
                            n_rsp.status = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_done    <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_free_ok <= n_free_ok;
            if (r_state == ST_CLEAR) r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) r_req <= i_req;
        r_x       <= n_x;
        r_idx     <= n_idx;
        r_step    <= n_step;
        r_cnt     <= n_cnt;
        r_free_at <= n_free_at;
        r_rsp     <= n_rsp;
    end

    // slot memories, registered read; the read address is the next probe
    always_ff @(posedge i_clk) begin
        if (w_mark_we) mem_mark[w_mark_addr] <= w_mark_data;
        r_mark_q <= mem_mark[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) mem_key[w_kv_addr] <= r_req.lookup_key;
        r_key_q <= mem_key[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_val_we) mem_val[w_kv_addr] <= r_req.new_value;
        r_val_q <= mem_val[w_rd_addr];
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
